// ===== hdl/string_key_exact_match_table_defines.svh =====
// Assertion macros used by the table's top-level RTL file.
// Each macro checks on the rising edge of clk and is switched off during rst.
`ifndef STRING_KEY_EXACT_MATCH_TABLE_DEFINES_SVH
`define STRING_KEY_EXACT_MATCH_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define SKEMT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("skemt assertion failed");
// Next-cycle implication
`define SKEMT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("skemt assertion failed");
`else
`define SKEMT_ASSERT_IMP(lbl, ante, cons)
`define SKEMT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/skemt_pkg.sv =====
package skemt_pkg;

  // Operation codes carried on the last byte of a key
  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  localparam int COUNT_W  = 7;
  localparam int KLEN_W   = 16;

  // Commands broadcast from the sequencer to every cell
  typedef struct packed {
    logic stream_wr;  // write the arriving key byte into the free cell
    logic cmp_en;     // compare read data with the arriving byte
    logic mism_clr;   // start a new key
    logic hit_load;   // capture the match result of each cell
    logic hit_shift;  // move match flags one cell toward cell 0
    logic len_add;    // store the key length in the free cell
    logic len_shift;  // move lengths down over the removed entry
    logic copy_wr;    // move key bytes down over the removed entry
  } cell_cmd_t;

endpackage

// ===== hdl/skemt_ram.sv =====
module skemt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/skemt_cell.sv =====
module skemt_cell #(
  parameter int KEY_BYTES = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  skemt_pkg::cell_cmd_t           cmd,
  input  logic                           sel_stream,
  input  logic                           sel_shift,
  input  logic [$clog2(KEY_BYTES)-1:0]   raddr,
  input  logic [$clog2(KEY_BYTES)-1:0]   stream_addr,
  input  logic [$clog2(KEY_BYTES)-1:0]   copy_addr,
  input  logic [7:0]                     stream_byte,
  input  logic [7:0]                     cmp_byte,
  input  logic [$clog2(KEY_BYTES)-1:0]   match_len,
  input  logic                           len_ok,
  input  logic [$clog2(KEY_BYTES)-1:0]   add_len,
  input  logic [7:0]                     nb_rdata,
  input  logic [$clog2(KEY_BYTES)-1:0]   nb_len,
  input  logic                           nb_hit,
  output logic [7:0]                     rdata,
  output logic [$clog2(KEY_BYTES)-1:0]   len,
  output logic                           hit
);
  import skemt_pkg::*;

  localparam int AW = $clog2(KEY_BYTES);

  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          mism;

  // Pick the write source: arriving key byte or neighbour's stored byte
  always_comb begin
    we    = (cmd.stream_wr && sel_stream) || (cmd.copy_wr && sel_shift);
    waddr = cmd.copy_wr ? copy_addr : stream_addr;
    wdata = cmd.copy_wr ? nb_rdata : stream_byte;
  end

  skemt_ram #(.WIDTH(8), .DEPTH(KEY_BYTES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Track mismatch, length and match flag of this entry
  always_ff @(posedge clk) begin
    if (rst) begin
      mism <= 1'b0;
      hit  <= 1'b0;
    end else begin
      if (cmd.mism_clr) begin
        mism <= 1'b0;
      end else if (cmd.cmp_en && (rdata != cmp_byte)) begin
        mism <= 1'b1;
      end
      if (cmd.hit_load) begin
        hit <= len_ok && !mism && (len == match_len);
      end else if (cmd.hit_shift) begin
        hit <= nb_hit;
      end
    end
    if (cmd.len_add && sel_stream) begin
      len <= add_len;
    end else if (cmd.len_shift && sel_shift) begin
      len <= nb_len;
    end
  end

endmodule

// ===== hdl/string_key_exact_match_table.sv =====
// Exact-match table of byte-string keys, kept in insertion order.
// Input channel (in_valid / in_stall): one key byte a word; key_last marks
// the byte that ends the key, and kind on that word picks lookup, add,
// remove or clear. Zero bytes are dropped from the key.
// Output channel (out_valid / out_stall): one word per key_last word, with
// ok and the entry count after the operation; other words give nothing.
// Sequence: a byte that does not end a key passes S_CMP and returns to idle.
// A last byte passes S_CMP and S_LOAD, then a scan over the stored entries,
// then compaction for a successful remove, and S_DONE hands over the result;
// clear skips the load and the scan.
// The scan shifts match flags down the row of cells one place a cycle, and
// compaction moves the stored bytes one address a cycle through each RAM.
// One word is processed at a time; in_stall is low only when idle.
// While the receiver stalls, the result is held and the block waits before
// presenting the next one. Reset empties the table and the key in progress.
module string_key_exact_match_table #(
  parameter int ENTRIES   = 64,
  parameter int KEY_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] kind,
  input  logic [7:0] key_byte,
  input  logic       key_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       ok,
  output logic [6:0] entry_count
);
  import skemt_pkg::*;

`include "string_key_exact_match_table_defines.svh"

  localparam int AW    = $clog2(KEY_BYTES);
  localparam int CW    = $clog2(ENTRIES + 1);
  localparam int KEEP  = KEY_BYTES - 1;
  localparam int CCW   = AW + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_CMP, S_LOAD, S_SCAN, S_COPY, S_DONE
  } state_t;

  state_t            state;
  logic [KLEN_W-1:0] key_length;
  logic [CW-1:0]     count;
  logic [7:0]        byte_q;
  logic [1:0]        kind_q;
  logic              last_q;
  logic              cmp_q;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     hit_idx;
  logic [CCW-1:0]    copy_cnt;
  logic              res_ok;

  logic              accept;
  logic              keep_room;
  logic              len_ok;
  logic [KLEN_W-1:0] kept_len;
  cell_cmd_t         cmd;
  logic [AW-1:0]     raddr;

  logic [7:0]        rdata [ENTRIES];
  logic [AW-1:0]     len   [ENTRIES];
  logic              hit   [ENTRIES];

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign keep_room = (key_length < KLEN_W'(KEEP));
  assign len_ok    = (key_length <= KLEN_W'(KEEP));
  assign kept_len  = keep_room ? key_length : KLEN_W'(KEEP);

  // Broadcast commands for the row of cells
  always_comb begin
    cmd           = '0;
    cmd.stream_wr = accept && (key_byte != 8'd0) && keep_room &&
                    (count < CW'(ENTRIES));
    cmd.cmp_en    = (state == S_CMP) && cmp_q;
    cmd.mism_clr  = (state == S_DONE) && !(out_valid && out_stall);
    cmd.hit_load  = (state == S_LOAD);
    cmd.hit_shift = (state == S_SCAN);
    cmd.len_add   = (state == S_SCAN) && (kind_q == KIND_ADD) && (idx == count) &&
                    (count < CW'(ENTRIES));
    cmd.len_shift = (state == S_COPY) && (copy_cnt == '0);
    cmd.copy_wr   = (state == S_COPY) && (copy_cnt != '0);
    raddr         = (state == S_COPY) ? copy_cnt[AW-1:0] : key_length[AW-1:0];
  end

  // Build the chain: each cell takes data from the next one up
  for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
    logic [7:0]    nb_rdata;
    logic [AW-1:0] nb_len;
    logic          nb_hit;
    logic          sel_stream;
    logic          sel_shift;
    logic [AW-1:0] copy_addr;

    if (j + 1 < ENTRIES) begin : g_nb
      assign nb_rdata = rdata[j+1];
      assign nb_len   = len[j+1];
      assign nb_hit   = hit[j+1];
    end else begin : g_end
      assign nb_rdata = 8'd0;
      assign nb_len   = '0;
      assign nb_hit   = 1'b0;
    end

    assign sel_stream = (count == CW'(j));
    assign sel_shift  = (CW'(j) >= hit_idx) && (CW'(j + 1) < count);
    assign copy_addr  = AW'(copy_cnt - CCW'(1));

    skemt_cell #(.KEY_BYTES(KEY_BYTES)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .sel_stream  (sel_stream),
      .sel_shift   (sel_shift),
      .raddr       (raddr),
      .stream_addr (key_length[AW-1:0]),
      .copy_addr   (copy_addr),
      .stream_byte (key_byte),
      .cmp_byte    (byte_q),
      .match_len   (key_length[AW-1:0]),
      .len_ok      (len_ok),
      .add_len     (kept_len[AW-1:0]),
      .nb_rdata    (nb_rdata),
      .nb_len      (nb_len),
      .nb_hit      (nb_hit),
      .rdata       (rdata[j]),
      .len         (len[j]),
      .hit         (hit[j])
    );
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      key_length <= '0;
      count      <= '0;
      out_valid  <= 1'b0;
      idx        <= '0;
      hit_idx    <= '0;
      copy_cnt   <= '0;
      res_ok     <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            byte_q <= key_byte;
            kind_q <= kind;
            last_q <= key_last;
            cmp_q  <= (key_byte != 8'd0) && keep_room;
            if ((key_byte != 8'd0) && (key_length != {KLEN_W{1'b1}})) begin
              key_length <= key_length + KLEN_W'(1);
            end
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (!last_q) begin
            state <= S_IDLE;
          end else if (kind_q == KIND_CLEAR) begin
            count  <= '0;
            res_ok <= 1'b1;
            state  <= S_DONE;
          end else begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          idx   <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          priority if (idx == count) begin
            // not found
            if (cmd.len_add) begin
              count  <= count + CW'(1);
              res_ok <= 1'b1;
            end else begin
              res_ok <= 1'b0;
            end
            state <= S_DONE;
          end else if (hit[0]) begin
            if (kind_q == KIND_REMOVE) begin
              hit_idx  <= idx;
              copy_cnt <= '0;
              state    <= S_COPY;
            end else begin
              res_ok <= (kind_q == KIND_LOOKUP);
              state  <= S_DONE;
            end
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_COPY: begin
          if (copy_cnt == CCW'(KEY_BYTES)) begin
            count  <= count - CW'(1);
            res_ok <= 1'b1;
            state  <= S_DONE;
          end else begin
            copy_cnt <= copy_cnt + CCW'(1);
          end
        end
        S_DONE: begin
          if (!(out_valid && out_stall)) begin
            out_valid  <= 1'b1;
            ok         <= res_ok;
            entry_count <= COUNT_W'(32'(count));
            key_length <= '0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SKEMT_ASSERT_IMP(a_count_bound, 1'b1, count <= CW'(ENTRIES))
  `SKEMT_ASSERT_IMP(a_copy_hit, state == S_COPY, hit_idx < count)
  `SKEMT_ASSERT_NXT(a_key_restart, cmd.mism_clr, key_length == '0 && state == S_IDLE)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import skemt_pkg::*;

  localparam int ENTRIES   = 64;
  localparam int KEY_BYTES = 64;
  localparam int KEEP      = KEY_BYTES - 1;
  localparam int LIMIT     = 2000000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] kind = KIND_LOOKUP;
  logic [7:0] key_byte = 8'd0;
  logic       key_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       ok;
  logic [6:0] entry_count;

  typedef struct {
    logic       ok;
    logic [6:0] count;
  } outcome_t;

  // Predicted table contents
  typedef logic [7:0] key_t [$];
  key_t       stored_keys [$];
  logic [7:0] pending_key [$];
  int         pending_len;
  outcome_t   outcome_q [$];

  int  cycles;
  int  errors;
  bit  hold_off;
  bit  draining;
  key_t known_keys [$];

  string_key_exact_match_table #(
    .ENTRIES(ENTRIES), .KEY_BYTES(KEY_BYTES)
  ) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .key_byte(key_byte), .key_last(key_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .ok(ok), .entry_count(entry_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort on runaway
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic int find_stored();
    if (pending_len > KEEP) return -1;
    foreach (stored_keys[e])
      if (stored_keys[e] == pending_key) return e;
    return -1;
  endfunction

  // Advance the table model by one word
  function automatic void table_step(logic [1:0] k, logic [7:0] b, logic last);
    outcome_t o;
    int hit;
    if (b != 0) begin
      if (pending_len < KEEP) pending_key.push_back(b);
      if (pending_len < 65535) pending_len++;
    end
    if (!last) return;
    o.ok = 1'b0;
    case (k)
      KIND_LOOKUP: o.ok = find_stored() >= 0;
      KIND_ADD: if (stored_keys.size() < ENTRIES && find_stored() < 0) begin
        stored_keys.push_back(pending_key);
        o.ok = 1'b1;
      end
      KIND_REMOVE: begin
        hit = find_stored();
        if (hit >= 0) begin
          stored_keys.delete(hit);
          o.ok = 1'b1;
        end
      end
      default: begin
        stored_keys.delete();
        o.ok = 1'b1;
      end
    endcase
    o.count = 7'(stored_keys.size());
    outcome_q.push_back(o);
    pending_key.delete();
    pending_len = 0;
  endfunction

  function automatic int short_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // Send one word, holding it until accepted
  task automatic send_word(logic [1:0] k, logic [7:0] b, logic last, bit gaps);
    int g;
    g = gaps ? short_gap() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    key_byte <= b;
    key_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    table_step(k, b, last);
  endtask

  task automatic send_key(key_t key, logic [1:0] k, bit gaps);
    int n;
    n = key.size();
    if (n == 0) begin
      send_word(k, 8'd0, 1'b1, gaps);
      return;
    end
    for (int i = 0; i < n; i++) send_word(k, key[i], i == n - 1, gaps);
  endtask

  function automatic key_t random_key(int len);
    key_t key;
    for (int i = 0; i < len; i++) key.push_back(8'($urandom_range(1, 255)));
    return key;
  endfunction

  // Pick a key that is usually short, sometimes reused, rarely long
  function automatic key_t pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && known_keys.size() > 0)
      return known_keys[$urandom_range(0, known_keys.size() - 1)];
    if (r < 50) return random_key($urandom_range(KEEP, KEY_BYTES + 3));
    return random_key($urandom_range(0, 4));
  endfunction

  // Check each result against the oldest prediction
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      if (outcome_q.size() == 0) begin
        $error("result with nothing expected: ok=%0d entry_count=%0d", ok, entry_count);
        errors++;
      end else begin
        want = outcome_q.pop_front();
        if (ok !== want.ok) begin
          $error("ok: expected %0d, actual %0d", want.ok, ok);
          errors++;
        end
        if (entry_count !== want.count) begin
          $error("entry_count: expected %0d, actual %0d", want.count, entry_count);
          errors++;
        end
      end
    end
  end

  // Receiver stall: random, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (draining) out_stall <= 1'b0;
    else if ($urandom_range(0, 3) == 0) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 9) < 3) || ($urandom_range(0, 49) == 0 && out_stall);
  end

  task automatic test_directed();
    key_t k;
    key_t full;
    send_key(k, KIND_LOOKUP, 0);         // empty key, absent
    send_key(k, KIND_ADD, 0);            // empty key stored
    send_key(k, KIND_LOOKUP, 0);
    send_word(KIND_ADD, 8'd0, 1'b0, 0);  // zero byte dropped
    send_word(KIND_ADD, 8'd0, 1'b1, 0);  // duplicate empty key
    k = '{8'hFF, 8'h01, 8'h80, 8'h7F};
    send_key(k, KIND_ADD, 0);
    send_key(k, KIND_LOOKUP, 0);
    full = random_key(KEEP);
    send_key(full, KIND_ADD, 0);
    send_key(full, KIND_LOOKUP, 0);
    full = random_key(KEY_BYTES + 2);    // long key: cut, never matches
    send_key(full, KIND_ADD, 1);
    send_key(full, KIND_ADD, 1);
    send_key(full, KIND_LOOKUP, 1);
    send_key(full, KIND_REMOVE, 1);
    send_key(k, KIND_REMOVE, 0);
    send_key(k, KIND_REMOVE, 0);
    send_word(KIND_CLEAR, 8'h55, 1'b1, 0);
    send_word(KIND_CLEAR, 8'hAA, 1'b1, 0);
  endtask

  task automatic test_fill_table();
    key_t k;
    // Fill past capacity, then remove from the middle
    for (int i = 0; i <= ENTRIES + 1; i++) begin
      k = '{i[7:0] + 8'd1, 8'h5A};
      send_key(k, KIND_ADD, 1);
    end
    for (int i = 10; i < 14; i++) begin
      k = '{i[7:0] + 8'd1, 8'h5A};
      send_key(k, KIND_REMOVE, 1);
    end
    k = '{8'd15, 8'h5A};
    send_key(k, KIND_LOOKUP, 1);
    send_word(KIND_CLEAR, 8'h00, 1'b1, 1);
  endtask

  task automatic test_back_pressure();
    key_t k;
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++) begin
        k = random_key(2);
        send_key(k, KIND_ADD, 0);
      end
    join
  endtask

  task automatic test_random();
    key_t k;
    int words;
    int r;
    words = 0;
    while (words < 240) begin
      r = $urandom_range(0, 99);
      k = pick_key();
      if (r < 3) begin
        send_word(KIND_CLEAR, 8'($urandom_range(0, 255)), 1'b1, 1);
        words++;
        continue;
      end
      if (k.size() > 0 && k.size() < 6 && known_keys.size() < 40) known_keys.push_back(k);
      // Sprinkle a zero byte now and then
      if ($urandom_range(0, 9) == 0) begin
        send_word(2'($urandom_range(0, 3)), 8'd0, 1'b0, 1);
        words++;
      end
      send_key(k, (r < 40) ? KIND_ADD : (r < 70) ? KIND_LOOKUP : KIND_REMOVE, 1);
      words += (k.size() == 0) ? 1 : k.size();
    end
  endtask

  initial begin
    cycles = 0;
    errors = 0;
    hold_off = 1'b0;
    draining = 1'b0;
    pending_len = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_fill_table();
    test_back_pressure();
    test_random();
    // Drain outstanding results
    in_valid <= 1'b0;
    draining = 1'b1;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (KEY_BYTES + ENTRIES + 20) @(posedge clk);
    if (errors == 0 && outcome_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
